/* design/cel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cel_pkg;

   // Sizing of the classifier and of the logarithm table.
   localparam int MAX_CLASSES       = 1024;
   localparam int LOG_TABLE_ENTRIES = 256;
   localparam int LOG_TABLE_BITS    = $clog2(LOG_TABLE_ENTRIES);

   // Field widths fixed by the interface.
   localparam int PROB_W    = 16;
   localparam int CLASS_W   = 11;
   localparam int COLUMN_W  = 10;
   localparam int ROWS_W    = 16;
   localparam int TERM_W    = 21;
   localparam int SUM_W     = 48;
   localparam int OUT_W     = 32;

   // The divider handles the 49-bit mean dividend; the gradient uses the top 32 bits.
   localparam int GRAD_DIV_W = 32;
   localparam int DIV_W      = SUM_W + 1;
   localparam int STEP_W     = $clog2(DIV_W + 1);

   // Fixed-point constants.
   localparam logic [PROB_W-1:0] Q15_ONE          = 16'h8000;
   localparam logic [15:0]       LN2_Q16          = 16'd45426;
   localparam logic [TERM_W-1:0] NEG_LN_FLOOR_Q16 = 21'd1358120;

   // Configuration register indexes.
   localparam int               CSR_INDEX_W     = 2;
   localparam logic [1:0]       CSR_TARGET_MODE = 2'd0;
   localparam logic [1:0]       CSR_BATCH_ROWS  = 2'd1;
   localparam logic [1:0]       CSR_CLASS_COUNT = 2'd2;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Table of round(65536 * ln(1 + i / LOG_TABLE_ENTRIES)), built at elaboration.
   typedef logic [15:0] log_table_type [LOG_TABLE_ENTRIES];

   // Restoring division of two constants, used only while the table is built.
   function automatic logic [63:0] table_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // One entry: 2 * atanh(i / (2n + i)) summed as a series in Q32, rounded to Q16.
   function automatic logic [15:0] ln_entry(input int unsigned i, input int unsigned n);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] k;
      z    = table_div({32'(i), 32'd0}, 64'(2 * n + i));
      z2   = (z * z) >> 32;
      term = z;
      acc  = '0;
      k    = '0;
      while (term != '0) begin
         acc  = acc + table_div(term, 64'd2 * k + 64'd1);
         term = (term * z2) >> 32;
         k    = k + 64'd1;
      end
      return 16'((64'd2 * acc + 64'd32768) >> 16);
   endfunction

   function automatic log_table_type build_log_table();
      log_table_type tbl;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         tbl[i] = ln_entry(unsigned'(i), unsigned'(LOG_TABLE_ENTRIES));
      end
      return tbl;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

   // One classified element as it travels from the front to the back.
   typedef struct packed {
      logic              neg;
      logic [PROB_W-1:0] mag;
      logic              add;
      logic [TERM_W-1:0] term;
      logic              last;
   } cel_item_type;

endpackage

`default_nettype wire

/* design/cel_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cel_front import cel_pkg::*; (
   input  logic                       target_mode,
   input  logic [CLASS_W-1:0]         class_count,
   input  logic [PROB_W-1:0]          probability,
   input  logic [PROB_W-1:0]          target_value,
   input  logic signed [PROB_W-1:0]   class_index,
   input  logic [COLUMN_W-1:0]        column,
   input  logic                       last_in_batch,
   output cel_item_type               item
);

   logic [CLASS_W-1:0]        bound;
   logic                      hit;
   logic [PROB_W-1:0]         target;
   logic                      add;
   logic [PROB_W:0]           diff;
   logic [3:0]                lead;
   logic [3:0]                shift;
   logic [14:0]               norm;
   logic [14:0]               frac;
   logic [LOG_TABLE_BITS-1:0] idx;
   logic [3:0]                octaves;
   logic [19:0]               octave_log;
   logic [TERM_W-1:0]         term_raw;
   logic [TERM_W-1:0]         term;

   // Class bound and the class-index hit test.
   assign bound = (class_count > CLASS_W'(MAX_CLASSES)) ? CLASS_W'(MAX_CLASSES) : class_count;
   assign hit   = ($unsigned(class_index) == {{(PROB_W-COLUMN_W){1'b0}}, column}) &&
                  ({1'b0, column} < bound);

   // Target and loss-enable for the selected mode.
   assign target = target_mode ? (hit ? Q15_ONE : '0) : target_value;
   assign add    = target_mode ? hit : (target_value != '0);

   // Signed difference p - t, split into sign and magnitude.
   assign diff = {1'b0, probability} - {1'b0, target};

   // Position of the leading one of a probability below one.
   always_comb begin
      lead = '0;
      for (int b = 0; b < 15; b++) begin
         if (probability[b]) begin
            lead = 4'(b);
         end
      end
   end

   // Mantissa bits below the leading one address the logarithm table.
   assign shift   = 4'd14 - lead;
   assign norm    = probability[14:0] << shift;
   assign frac    = {norm[13:0], 1'b0};
   assign idx     = frac[14 -: LOG_TABLE_BITS];
   assign octaves = 4'd15 - lead;

   assign octave_log = octaves * LN2_Q16;
   assign term_raw   = {1'b0, octave_log} - {{(TERM_W-16){1'b0}}, LOG_TABLE[idx]};

   // Zero probability takes the floor term; one and above give no loss.
   always_comb begin
      if (probability == '0) begin
         term = NEG_LN_FLOOR_Q16;
      end else if (probability[PROB_W-1]) begin
         term = '0;
      end else begin
         term = term_raw;
      end
   end

   assign item.neg  = diff[PROB_W];
   assign item.mag  = diff[PROB_W] ? PROB_W'(-diff) : diff[PROB_W-1:0];
   assign item.add  = add;
   assign item.term = term;
   assign item.last = last_in_batch;

endmodule

`default_nettype wire

/* design/cel_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cel_queue import cel_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cel_item_type push_data,
   output logic         full,
   input  logic         pop,
   output cel_item_type pop_data,
   output logic         empty
);

   cel_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/cel_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cel_back import cel_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [ROWS_W-1:0]  batch_rows,
   input  cel_item_type       item,
   input  logic               item_valid,
   output logic               item_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [OUT_W-1:0]   rsp_gradient,
   output logic [OUT_W-1:0]   rsp_mean_loss,
   output logic               rsp_loss_valid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GRAD = 2'd1;
   localparam logic [1:0] ST_MEAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [STEP_W-1:0] GRAD_STEPS = STEP_W'(GRAD_DIV_W);
   localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DIV_W);

   logic [1:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [DIV_W-1:0]    dvd_ff, dvd_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [ROWS_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                neg_ff, neg_in;
   logic                last_ff, last_in;
   logic [OUT_W-1:0]    grad_ff, grad_in;
   logic [OUT_W-1:0]    mean_ff, mean_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_gradient_ff, rsp_gradient_in;
   logic [OUT_W-1:0]    rsp_mean_loss_ff, rsp_mean_loss_in;
   logic                rsp_loss_valid_ff, rsp_loss_valid_in;

   logic [ROWS_W-1:0]     rows;
   logic [ROWS_W-2:0]     half;
   logic [GRAD_DIV_W-1:0] grad_dividend;
   logic [DIV_W-1:0]      mean_dividend;
   logic [DIV_W-1:0]      sum_add;
   logic [ROWS_W:0]       rem_shift;
   logic                  rem_ge;
   logic [ROWS_W-1:0]     rem_step;
   logic [DIV_W-1:0]      quo_step;
   logic                  out_load;

   // A zero row count divides as one; the rounding offset is half the divisor.
   assign rows = (batch_rows == '0) ? ROWS_W'(1) : batch_rows;
   assign half = rows[ROWS_W-1:1];

   assign grad_dividend = {1'b0, item.mag, 15'd0} + {{(GRAD_DIV_W-ROWS_W+1){1'b0}}, half};
   assign mean_dividend = {1'b0, sum_ff} + {{(DIV_W-ROWS_W+1){1'b0}}, half};
   assign sum_add       = {1'b0, sum_ff} + {{(DIV_W-TERM_W){1'b0}}, item.term};

   // One restoring division step per cycle.
   assign rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, rows});
   assign rem_step  = rem_ge ? ROWS_W'(rem_shift - {1'b0, rows}) : rem_shift[ROWS_W-1:0];
   assign quo_step  = {quo_ff[DIV_W-2:0], rem_ge};

   // Sequencer: accumulate, divide the gradient, divide the mean on the last element.
   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      steps_in = steps_ff;
      neg_in   = neg_ff;
      last_in  = last_ff;
      grad_in  = grad_ff;
      mean_in  = mean_ff;
      item_pop = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.add) begin
                  sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
               end
               dvd_in   = {grad_dividend, {(DIV_W-GRAD_DIV_W){1'b0}}};
               quo_in   = '0;
               rem_in   = '0;
               steps_in = GRAD_STEPS;
               neg_in   = item.neg;
               last_in  = item.last;
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            dvd_in   = {dvd_ff[DIV_W-2:0], 1'b0};
            quo_in   = quo_step;
            rem_in   = rem_step;
            steps_in = steps_ff - 1'b1;
            if (steps_ff == STEP_W'(1)) begin
               grad_in = neg_ff ? (OUT_W'(0) - quo_step[OUT_W-1:0]) : quo_step[OUT_W-1:0];
               if (last_ff) begin
                  dvd_in   = mean_dividend;
                  quo_in   = '0;
                  rem_in   = '0;
                  steps_in = MEAN_STEPS;
                  state_in = ST_MEAN;
               end else begin
                  mean_in  = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_MEAN: begin
            dvd_in   = {dvd_ff[DIV_W-2:0], 1'b0};
            quo_in   = quo_step;
            rem_in   = rem_step;
            steps_in = steps_ff - 1'b1;
            if (steps_ff == STEP_W'(1)) begin
               mean_in  = (|quo_step[DIV_W-1:OUT_W]) ? '1 : quo_step[OUT_W-1:0];
               sum_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: holds one finished transaction for the receiver.
   always_comb begin
      rsp_valid_in      = out_load || (rsp_valid_ff && !rsp_pop);
      rsp_gradient_in   = out_load ? grad_ff : rsp_gradient_ff;
      rsp_mean_loss_in  = out_load ? mean_ff : rsp_mean_loss_ff;
      rsp_loss_valid_in = out_load ? last_ff : rsp_loss_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff            <= dvd_in;
      quo_ff            <= quo_in;
      rem_ff            <= rem_in;
      steps_ff          <= steps_in;
      neg_ff            <= neg_in;
      last_ff           <= last_in;
      grad_ff           <= grad_in;
      mean_ff           <= mean_in;
      rsp_gradient_ff   <= rsp_gradient_in;
      rsp_mean_loss_ff  <= rsp_mean_loss_in;
      rsp_loss_valid_ff <= rsp_loss_valid_in;
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_gradient   = rsp_gradient_ff;
   assign rsp_mean_loss  = rsp_mean_loss_ff;
   assign rsp_loss_valid = rsp_loss_valid_ff;

endmodule

`default_nettype wire

/* design/cross_entropy_loss_and_gradient_top.sv */
// Cross-entropy loss and gradient for a softmax output, one element per transaction.
// Request channel (req_*): push an element while full is low; each carries a Q1.15
// probability, a soft/one-hot target, the row's class index, its column and a
// last-of-batch flag. Response channel (rsp_*): while empty is low the oldest result
// is on the ports; pop takes it. Each element yields one result: the gradient
// (p - t) / rows in Q1.30, and on the batch's last element the mean loss in Q16.16.
// Configuration (csr_*): target mode, batch row count and class count, written by
// index while the block is idle; csr_ready is always high.
// In the back end an element is taken from the queue, passes the bit-serial divider
// for its gradient and is handed to the output register; the last element of a batch
// also passes the divider for the mean. The single divider sets the rate: the back
// takes no new element until it has handed the last one on. A two-entry queue lets the
// front accept elements while the back works, and the output register lets the back
// finish an element while the receiver stalls; full rises when the queue is full.
// Reset empties both, clears the loss sum and restores target mode 0, one row and
// 1024 classes.
`timescale 1ns / 1ps
`default_nettype none

module cross_entropy_loss_and_gradient_top import cel_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [PROB_W-1:0]         req_probability,
   input  logic [PROB_W-1:0]         req_target_value,
   input  logic signed [PROB_W-1:0]  req_class_index,
   input  logic [COLUMN_W-1:0]       req_column,
   input  logic                      req_last_in_batch,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [OUT_W-1:0]   rsp_gradient,
   output logic [OUT_W-1:0]          rsp_mean_loss,
   output logic                      rsp_loss_valid,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [ROWS_W-1:0]         csr_data
);

   logic               target_mode_ff, target_mode_in;
   logic [ROWS_W-1:0]  batch_rows_ff, batch_rows_in;
   logic [CLASS_W-1:0] class_count_ff, class_count_in;

   cel_item_type front_item;
   cel_item_type queue_item;
   logic         queue_empty;
   logic         queue_pop;
   logic [OUT_W-1:0] gradient_bits;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      target_mode_in = target_mode_ff;
      batch_rows_in  = batch_rows_ff;
      class_count_in = class_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TARGET_MODE: target_mode_in = csr_data[0];
            CSR_BATCH_ROWS:  batch_rows_in  = csr_data;
            CSR_CLASS_COUNT: class_count_in = csr_data[CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mode_ff <= 1'b0;
         batch_rows_ff  <= ROWS_W'(1);
         class_count_ff <= CLASS_W'(1024);
      end else begin
         target_mode_ff <= target_mode_in;
         batch_rows_ff  <= batch_rows_in;
         class_count_ff <= class_count_in;
      end
   end

   // Front end: classify the incoming element.
   cel_front u_front (
      .target_mode   (target_mode_ff),
      .class_count   (class_count_ff),
      .probability   (req_probability),
      .target_value  (req_target_value),
      .class_index   (req_class_index),
      .column        (req_column),
      .last_in_batch (req_last_in_batch),
      .item          (front_item)
   );

   // Queue between the front and the back.
   cel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_item),
      .empty     (queue_empty)
   );

   // Back end: accumulate the loss and divide by the row count.
   cel_back u_back (
      .clock          (clock),
      .reset          (reset),
      .batch_rows     (batch_rows_ff),
      .item           (queue_item),
      .item_valid     (!queue_empty),
      .item_pop       (queue_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_gradient   (gradient_bits),
      .rsp_mean_loss  (rsp_mean_loss),
      .rsp_loss_valid (rsp_loss_valid)
   );

   assign rsp_gradient = $signed(gradient_bits);

endmodule

`default_nettype wire

/* design/cel_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cel_checker import cel_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_push,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input logic signed [OUT_W-1:0]   rsp_gradient,
   input logic [OUT_W-1:0]          rsp_mean_loss,
   input logic                      rsp_loss_valid
);

   // After reset both sides come up idle.
   a_reset_idle: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("block not idle after reset");

   // A waiting result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_gradient) && $stable(rsp_mean_loss) &&
          $stable(rsp_loss_valid)))
      else $error("waiting result changed before it was taken");

   // A result that does not close a batch carries no mean loss.
   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_loss_valid) |-> (rsp_mean_loss == '0))
      else $error("mean loss on a result that does not close a batch");

   // With nothing pushed, the request side cannot turn full.
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("full rose without a push");

endmodule

bind cross_entropy_loss_and_gradient_top cel_checker u_cel_checker (.*);

`default_nettype wire
